[rtl/ordered_list_engine_core_defines.svh]
// Assertion macros for the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent holds in a cycle, consequent in the same cycle.
`define OLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent holds in a cycle, consequent in the following one.
`define OLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define OLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/ole_pkg.sv]
// Package: beat types, operation and status codes for the ordered list engine.
`timescale 1ns / 1ps
package ole_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned LEN_W    = 5;

  localparam logic [KIND_W-1:0] KIND_INS_END   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_END   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_POS   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LIST      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic        [KIND_W-1:0]  kind;
    logic signed [VALUE_W-1:0] value;
    logic        [POS_W-1:0]   position;
  } in_t;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic signed [ITEM_W-1:0]   item;
    logic                       last;
    logic        [LEN_W-1:0]    length;
  } out_t;

endpackage

[rtl/ole_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ordered_list_engine_core.sv]
// Ordered list engine: sequencer, shared pointer step unit and element RAM.
// Insert at 0-based index k: each element from the tail down to k moves up by a read then a write,
// then the new value is written and the result loaded. Delete at index k pulls each later element
// forward the same way. Listing reads and sends one element at a time, waiting while the sink stalls.
// Not ready while an operation runs; a result register lets the next beat in while it waits.
// Reset clears count, state and output valid at once; the element RAM is not cleared.
`timescale 1ns / 1ps
`include "ordered_list_engine_core_defines.svh"
module ordered_list_engine_core
  import ole_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PCW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_WR  = 3'd2;
  localparam logic [2:0] S_DEL_RD  = 3'd3;
  localparam logic [2:0] S_DEL_WR  = 3'd4;
  localparam logic [2:0] S_LST_RD  = 3'd5;
  localparam logic [2:0] S_LST_OUT = 3'd6;
  localparam logic [2:0] S_RESP    = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [STATUS_W-1:0]   st_q, st_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]  ptr_inc, ptr_dec;
  logic [PCW-1:0] pos_w, cnt_w;
  logic           full, out_free, lst_last;

  ole_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared pointer step unit
  assign ptr_inc = ptr_q + CW'(1);
  assign ptr_dec = ptr_q - CW'(1);

  assign pos_w    = PCW'(in_data_i.position);
  assign cnt_w    = PCW'(cnt_q);
  assign full     = (cnt_q == CW'(CAPACITY));
  assign out_free = !out_valid_q || out_ready_i;
  assign lst_last = (ptr_inc == cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    val_d       = val_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = ptr_q[AW-1:0];
    ram_raddr   = ptr_q[AW-1:0];
    ram_wdata   = ram_rdata;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          val_d = DATA_WIDTH'(in_data_i.value);
          st_d  = ST_OK;
          ptr_d = cnt_q;
          case (in_data_i.kind)
            KIND_INS_END, KIND_INS_FRONT, KIND_INS_POS: begin
              if (full) begin
                st_d    = ST_FULL;
                state_d = S_RESP;
              end else if (in_data_i.kind == KIND_INS_END) begin
                idx_d   = cnt_q;
                state_d = S_INS_RD;
              end else if (in_data_i.kind == KIND_INS_FRONT) begin
                idx_d   = '0;
                state_d = S_INS_RD;
              end else if (pos_w == '0 || pos_w > cnt_w + PCW'(1)) begin
                st_d    = ST_INVALID;
                state_d = S_RESP;
              end else begin
                idx_d   = CW'(pos_w - PCW'(1));
                state_d = S_INS_RD;
              end
            end
            KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_POS: begin
              if (cnt_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_RESP;
              end else if (in_data_i.kind == KIND_DEL_FRONT) begin
                ptr_d   = '0;
                state_d = S_DEL_RD;
              end else if (in_data_i.kind == KIND_DEL_END) begin
                ptr_d   = cnt_q - CW'(1);
                state_d = S_DEL_RD;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                st_d    = ST_INVALID;
                state_d = S_RESP;
              end else begin
                ptr_d   = CW'(pos_w - PCW'(1));
                state_d = S_DEL_RD;
              end
            end
            KIND_LIST: begin
              if (cnt_q == '0) begin
                st_d    = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                ptr_d   = '0;
                state_d = S_LST_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      // walk from the tail down to the gap, then drop the new value in
      S_INS_RD: begin
        if (ptr_q == idx_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AW-1:0];
          ram_wdata = val_q;
          cnt_d     = cnt_q + CW'(1);
          state_d   = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_dec[AW-1:0];
          state_d   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_dec;
        state_d = S_INS_RD;
      end
      // close the gap by pulling each later element one place forward
      S_DEL_RD: begin
        if (ptr_inc >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc[AW-1:0];
          state_d   = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_inc;
        state_d = S_DEL_RD;
      end
      S_LST_RD: begin
        ram_re  = 1'b1;
        state_d = S_LST_OUT;
      end
      S_LST_OUT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.status  = ST_OK;
          out_d.item    = ITEM_W'($signed(ram_rdata));
          out_d.last    = lst_last;
          out_d.length  = LEN_W'(cnt_q);
          if (lst_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_inc;
            state_d = S_LST_RD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.status = st_q;
          out_d.item   = '0;
          out_d.last   = 1'b1;
          out_d.length = LEN_W'(cnt_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    idx_q <= idx_d;
    val_q <= val_d;
    st_q  <= st_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `OLE_ASSERT_SAME(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(CAPACITY), "count above capacity")
  `OLE_ASSERT_SAME(a_err_item_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_OK, out_data_o.item == '0 && out_data_o.last, "error beat with item or not last")
  `OLE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.kind != KIND_NONE, !in_ready_o, "ready straight after an operation beat")
  `OLE_ASSERT_NEXT(a_cnt_step, clk_i, rst_ni, 1'b1, cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CW'(1) || cnt_q == $past(cnt_q) - CW'(1), "count moved by more than one")

endmodule

[tb/sv/ordered_list_engine_core_test.sv]
// Testbench for the ordered list engine: directed and random list operations against a shadow list.
`timescale 1ns / 1ps
module ordered_list_engine_core_test;
  import ole_pkg::*;

  localparam int unsigned CAP            = 16;
  localparam int unsigned DRAIN_TAIL     = 40;    // covers the longest element shift
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  ordered_list_engine_core #(
    .CAPACITY  (CAP),
    .DATA_WIDTH(32)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // shadow copy of the list contents
  logic signed [VALUE_W-1:0] shadow_list [CAP];
  int unsigned               shadow_len;
  out_t                      pending_results [$];
  out_t                      want;
  int unsigned               errors;
  int unsigned               idle_cycles;
  int unsigned               snd_idle;
  int unsigned               rcv_stall;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic in_t beat(logic [KIND_W-1:0] k, logic signed [VALUE_W-1:0] v,
                               logic [POS_W-1:0] p);
    in_t b;
    b.kind     = k;
    b.value    = v;
    b.position = p;
    return b;
  endfunction

  function automatic void insert_elem(int unsigned idx, logic signed [VALUE_W-1:0] v);
    for (int unsigned i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[idx] = v;
    shadow_len++;
  endfunction

  function automatic void delete_elem(int unsigned idx);
    for (int unsigned i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
  endfunction

  // Update the shadow list for one accepted beat and queue the result beats it causes.
  function automatic void apply_list_op(in_t op);
    out_t r;
    r        = '0;
    r.status = ST_OK;
    r.last   = 1'b1;
    case (op.kind)
      KIND_INS_END, KIND_INS_FRONT, KIND_INS_POS: begin
        if (shadow_len >= CAP) r.status = ST_FULL;
        else if (op.kind == KIND_INS_END) insert_elem(shadow_len, op.value);
        else if (op.kind == KIND_INS_FRONT) insert_elem(0, op.value);
        else if (op.position < 1 || op.position > shadow_len + 1) r.status = ST_INVALID;
        else insert_elem(op.position - 1, op.value);
        r.length = LEN_W'(shadow_len);
        pending_results.push_back(r);
      end
      KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_POS: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (op.kind == KIND_DEL_FRONT) delete_elem(0);
        else if (op.kind == KIND_DEL_END) delete_elem(shadow_len - 1);
        else if (op.position < 1 || op.position > shadow_len) r.status = ST_INVALID;
        else delete_elem(op.position - 1);
        r.length = LEN_W'(shadow_len);
        pending_results.push_back(r);
      end
      KIND_LIST: begin
        r.length = LEN_W'(shadow_len);
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (int unsigned i = 0; i < shadow_len; i++) begin
            r.item = shadow_list[i];
            r.last = (i + 1 == shadow_len);
            pending_results.push_back(r);
          end
        end
      end
      default: ;  // unused kind: no result
    endcase
  endfunction

  task automatic send_beat(input in_t b);
    while ($urandom_range(99) < snd_idle) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    apply_list_op(b);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // Mostly in-range positions; the rest spread over the whole field.
  function automatic logic [POS_W-1:0] pick_pos(int unsigned hi);
    if (hi >= 1 && $urandom_range(99) < 80) return POS_W'($urandom_range(hi, 1));
    return POS_W'($urandom_range(63));
  endfunction

  function automatic in_t random_beat();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return beat(KIND_INS_END, $urandom, POS_W'($urandom));
    if (r < 24) return beat(KIND_INS_FRONT, $urandom, POS_W'($urandom));
    if (r < 40) return beat(KIND_INS_POS, $urandom, pick_pos(shadow_len + 1));
    if (r < 50) return beat(KIND_DEL_FRONT, $urandom, POS_W'($urandom));
    if (r < 60) return beat(KIND_DEL_END, $urandom, POS_W'($urandom));
    if (r < 76) return beat(KIND_DEL_POS, $urandom, pick_pos(shadow_len));
    if (r < 95) return beat(KIND_LIST, $urandom, POS_W'($urandom));
    return beat(KIND_NONE, $urandom, POS_W'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_empty_list();
    send_beat(beat(KIND_LIST, 0, 0));
    send_beat(beat(KIND_DEL_FRONT, 0, 0));
    send_beat(beat(KIND_DEL_END, 0, 0));
    send_beat(beat(KIND_DEL_POS, 0, 1));
    send_beat(beat(KIND_INS_POS, 32'sd7, 0));
    send_beat(beat(KIND_INS_POS, 32'sd7, 2));
  endtask

  task automatic test_positions();
    send_beat(beat(KIND_INS_END, 32'sh7fff_ffff, 0));
    send_beat(beat(KIND_INS_FRONT, 32'sh8000_0000, 6'h3f));
    send_beat(beat(KIND_INS_POS, 32'sd0, 2));
    send_beat(beat(KIND_INS_POS, 32'sh5a5a_5a5a, 4));  // count + 1 appends
    send_beat(beat(KIND_INS_POS, -32'sd1, 6'h3f));
    send_beat(beat(KIND_INS_POS, -32'sd1, 6));
    send_beat(beat(KIND_DEL_POS, 0, 0));
    send_beat(beat(KIND_DEL_POS, 0, 5));
    send_beat(beat(KIND_DEL_POS, 0, 6'h3f));
    send_beat(beat(KIND_NONE, 32'sh1234_5678, 1));
    send_beat(beat(KIND_LIST, 0, 0));
    send_beat(beat(KIND_DEL_POS, 0, 2));
    send_beat(beat(KIND_DEL_FRONT, 0, 0));
    send_beat(beat(KIND_DEL_END, 0, 0));
    send_beat(beat(KIND_LIST, 0, 0));
    send_beat(beat(KIND_DEL_POS, 0, 1));
    send_beat(beat(KIND_LIST, 0, 0));
  endtask

  // Fill to capacity, poke the full store, then empty it and poke the empty list.
  task automatic test_fill_and_drain();
    while (shadow_len < CAP) begin
      case ($urandom_range(2))
        0:       send_beat(beat(KIND_INS_END, $urandom, POS_W'($urandom)));
        1:       send_beat(beat(KIND_INS_FRONT, $urandom, POS_W'($urandom)));
        default: send_beat(beat(KIND_INS_POS, $urandom, POS_W'($urandom_range(shadow_len + 1, 1))));
      endcase
    end
    send_beat(beat(KIND_INS_END, $urandom, POS_W'($urandom)));
    send_beat(beat(KIND_INS_FRONT, $urandom, POS_W'($urandom)));
    send_beat(beat(KIND_INS_POS, $urandom, POS_W'($urandom)));
    send_beat(beat(KIND_LIST, $urandom, POS_W'($urandom)));
    while (shadow_len > 0) begin
      case ($urandom_range(2))
        0:       send_beat(beat(KIND_DEL_FRONT, $urandom, POS_W'($urandom)));
        1:       send_beat(beat(KIND_DEL_END, $urandom, POS_W'($urandom)));
        default: send_beat(beat(KIND_DEL_POS, $urandom, POS_W'($urandom_range(shadow_len, 1))));
      endcase
    end
    send_beat(beat(KIND_DEL_FRONT, $urandom, POS_W'($urandom)));
    send_beat(beat(KIND_DEL_END, $urandom, POS_W'($urandom)));
    send_beat(beat(KIND_DEL_POS, $urandom, POS_W'($urandom)));
    send_beat(beat(KIND_LIST, $urandom, POS_W'($urandom)));
  endtask

  task automatic test_random_ops(input int unsigned n);
    in_t         b;
    int unsigned done;
    done = 0;
    while (done < n) begin
      b = random_beat();
      send_beat(b);
      if (b.kind != KIND_NONE) done++;
      if (done == n / 2 && b.kind != KIND_NONE) wait_drained();  // let the output side catch up
    end
  endtask

  task automatic run_phase(input int unsigned snd, input int unsigned rcv);
    snd_idle  = snd;
    rcv_stall = rcv;
    test_fill_and_drain();
    test_random_ops(65);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------

  always @(negedge clk_i) out_ready_i = ($urandom_range(99) >= rcv_stall);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d item %0d",
               out_data_o.status, out_data_o.item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.item !== want.item) begin
          $error("item: expected %0d, actual %0d", want.item, out_data_o.item);
          errors++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data_o.last);
          errors++;
        end
        if (out_data_o.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, out_data_o.length);
          errors++;
        end
      end
    end
  end

  // no beat on either side for too long means the block has hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    shadow_len  = 0;
    errors      = 0;
    idle_cycles = 0;
    snd_idle    = 0;
    rcv_stall   = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_positions();
    wait_drained();

    run_phase(0, 0);
    run_phase(74, 0);
    run_phase(0, 74);
    run_phase(32, 32);

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
